>>> rtl/crs_pkg.sv
// Shared types and constants of the cubic fractional resampler.
`default_nettype none

package crs_pkg;

    // Fixed-point layout
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = PHASE_FRAC_BITS;
    localparam int RATE_W          = PHASE_FRAC_BITS + 2;
    localparam int SAMPLE_W        = 16;
    localparam int OUT_W           = 18;
    localparam int GUARD_BITS      = 16;
    localparam int COEF_W          = 20;
    localparam int H_W             = COEF_W + GUARD_BITS + 4;
    localparam int PROD_W          = H_W + PHASE_W + 1;
    localparam int V_W             = 24;
    localparam int W_W             = 21;

    // floor(w / 6) as (w * RECIP) >> RECIP_SHIFT, exact for w below 2^W_W
    localparam int RECIP_W         = 22;
    localparam int RECIP_SHIFT     = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(2796203);

    // 6 * 2^(OUT_W-1): offset that maps the unsaturated range onto [0, 2*SAT_OFS)
    localparam int SAT_OFS         = 786432;
    localparam int SAT_SPAN        = 2 * SAT_OFS;

    localparam logic signed [H_W-1:0] ROUND_OFS = H_W'(3) <<< GUARD_BITS;

    localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(1) << (PHASE_FRAC_BITS - 2);
    localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(3) << PHASE_FRAC_BITS;
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1) << PHASE_FRAC_BITS;

    // Run length cap: index of the fourth output of one item
    localparam logic [1:0] RUN_LAST = 2'd3;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] b0;
        logic signed [SAMPLE_W-1:0] b1;
        logic signed [SAMPLE_W-1:0] b2;
        logic signed [SAMPLE_W-1:0] b3;
        logic [PHASE_W-1:0]         phase;
        logic                       last;
    } crs_job_t;

    typedef struct packed {
        logic     valid;
        crs_job_t job;
    } crs_push_t;

endpackage

`default_nettype wire

>>> rtl/crs_front.sv
// Front end: configuration, sample history and phase accumulator; issues one job per output.
`default_nettype none

module crs_front
    import crs_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] raw_sample,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [RATE_W-1:0]          cfg_data,
    output crs_push_t                       push,
    input  wire logic                       queue_full
);

    logic signed [SAMPLE_W-1:0] hist_reg [4];
    logic [PHASE_W-1:0]         phase_reg;
    logic [1:0]                 owed_reg;
    logic [1:0]                 count_reg;
    logic                       busy_reg;
    logic [RATE_W-1:0]          rate_reg;
    logic                       fmt_reg;

    logic                       in_accept;
    logic signed [SAMPLE_W-1:0] sample_c;
    logic [1:0]                 owed_dec;
    logic [RATE_W-1:0]          acc;
    logic [1:0]                 owed_new;
    logic                       run_last;
    logic                       do_push;
    logic [RATE_W-1:0]          rate_clamped;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg;
    assign in_accept = in_valid && !busy_reg;

    // 8-bit format: low byte as signed, times 256
    assign sample_c = fmt_reg ? {raw_sample[7:0], 8'h00} : raw_sample;
    assign owed_dec = (owed_reg != 2'd0) ? owed_reg - 2'd1 : 2'd0;

    assign acc      = RATE_W'(phase_reg) + rate_reg;
    assign owed_new = acc[PHASE_FRAC_BITS +: 2];
    assign run_last = (owed_new != 2'd0) || (count_reg == RUN_LAST);
    assign do_push  = busy_reg && !queue_full;

    always_comb
    begin
        if (cfg_data < RATE_MIN)
        begin
            rate_clamped = RATE_MIN;
        end
        else if (cfg_data > RATE_MAX)
        begin
            rate_clamped = RATE_MAX;
        end
        else
        begin
            rate_clamped = cfg_data;
        end
    end

    always_comb
    begin
        push.valid     = do_push;
        push.job.b0    = hist_reg[0];
        push.job.b1    = hist_reg[1];
        push.job.b2    = hist_reg[2];
        push.job.b3    = hist_reg[3];
        push.job.phase = phase_reg;
        push.job.last  = run_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
            fmt_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_STEP_RATE:     rate_reg <= rate_clamped;
                REG_SAMPLE_FORMAT: fmt_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                hist_reg[i] <= '0;
            end
            phase_reg <= '0;
            owed_reg  <= 2'd1;
            count_reg <= 2'd0;
            busy_reg  <= 1'b0;
        end
        else if (in_accept)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= hist_reg[3];
            hist_reg[3] <= sample_c;
            owed_reg    <= owed_dec;
            count_reg   <= 2'd0;
            busy_reg    <= (owed_dec == 2'd0);
        end
        else if (do_push)
        begin
            // advance phase once per issued output
            phase_reg <= acc[PHASE_W-1:0];
            owed_reg  <= owed_new;
            count_reg <= count_reg + 2'd1;
            if (run_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/crs_queue.sv
// Short job queue between the front end and the interpolator.
`default_nettype none

module crs_queue
    import crs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  crs_push_t push,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output crs_job_t  head
);

    crs_job_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/crs_back.sv
// Interpolator: Horner evaluation with one shared multiplier, rounding, saturation, output register.
`default_nettype none

module crs_back
    import crs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 queue_empty,
    input  crs_job_t                  head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [OUT_W-1:0]   interpolated_sample,
    output logic                      last_of_run
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;

    logic [2:0]                state_reg;
    logic [1:0]                step_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic                      last_reg;
    logic signed [COEF_W-1:0]  c2_reg;
    logic signed [COEF_W-1:0]  c1_reg;
    logic signed [COEF_W-1:0]  c0_reg;
    logic signed [H_W-1:0]     h_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [W_W-1:0]            w_reg;
    logic                      sat_hi_reg;
    logic                      sat_lo_reg;
    logic                      out_valid_reg;
    logic signed [OUT_W-1:0]   out_sample_reg;
    logic                      out_last_reg;

    logic signed [COEF_W-1:0]  e0, e1, e2, e3;
    logic signed [COEF_W-1:0]  c1_c, c2_c, c3_c, c0_c;
    logic signed [COEF_W-1:0]  coef_sel;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [H_W-1:0]     h_add;
    logic signed [H_W-1:0]     h_round;
    logic signed [V_W-1:0]     v_c;
    logic signed [V_W-1:0]     w_full;
    logic [W_W+RECIP_W-1:0]    qprod;
    logic [OUT_W-1:0]          q_c;
    logic signed [OUT_W-1:0]   y_c;
    logic                      out_free;

    assign out_valid           = out_valid_reg;
    assign interpolated_sample = out_sample_reg;
    assign last_of_run         = out_last_reg;
    assign out_free            = !out_valid_reg || !out_stall;
    assign pop                 = (state_reg == ST_IDLE) && !queue_empty;

    // Cubic Lagrange polynomial coefficients, scaled by 6
    assign e0   = COEF_W'(head.b0);
    assign e1   = COEF_W'(head.b1);
    assign e2   = COEF_W'(head.b2);
    assign e3   = COEF_W'(head.b3);
    assign c1_c = (e2 <<< 2) + (e2 <<< 1) - (e0 <<< 1) - (e1 <<< 1) - e1 - e3;
    assign c2_c = (e0 <<< 1) + e0 - (e1 <<< 2) - (e1 <<< 1) + (e2 <<< 1) + e2;
    assign c3_c = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
    assign c0_c = (e1 <<< 2) + (e1 <<< 1);

    always_comb
    begin
        case (step_reg)
            2'd0:    coef_sel = c2_reg;
            2'd1:    coef_sel = c1_reg;
            default: coef_sel = c0_reg;
        endcase
    end

    assign prod_c = h_reg * $signed({1'b0, phase_reg});
    // floor shift by the phase fraction width is a plain part-select
    assign h_add  = (H_W'(coef_sel) <<< GUARD_BITS) + prod_reg[PHASE_FRAC_BITS +: H_W];

    assign h_round = h_reg + ROUND_OFS;
    assign v_c     = h_round[GUARD_BITS +: V_W];
    assign w_full  = v_c + V_W'(SAT_OFS);

    assign qprod = w_reg * RECIP;
    assign q_c   = qprod[RECIP_SHIFT +: OUT_W];
    // subtract 2^(OUT_W-1): flip the top bit
    assign y_c   = $signed({~q_c[OUT_W-1], q_c[OUT_W-2:0]});

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    c2_reg    <= c2_c;
                    c1_reg    <= c1_c;
                    c0_reg    <= c0_c;
                    h_reg     <= H_W'(c3_c) <<< GUARD_BITS;
                    phase_reg <= head.phase;
                    last_reg  <= head.last;
                end
            end
            ST_MUL:
            begin
                prod_reg <= prod_c;
            end
            ST_ADD:
            begin
                h_reg <= h_add;
            end
            ST_FIN:
            begin
                w_reg      <= w_full[W_W-1:0];
                sat_lo_reg <= w_full[V_W-1];
                sat_hi_reg <= (w_full >= V_W'(SAT_SPAN));
            end
            ST_DIV:
            begin
                if (out_free)
                begin
                    out_last_reg <= last_reg;
                    if (sat_hi_reg)
                    begin
                        out_sample_reg <= {1'b0, {(OUT_W-1){1'b1}}};
                    end
                    else if (sat_lo_reg)
                    begin
                        out_sample_reg <= {1'b1, {(OUT_W-1){1'b0}}};
                    end
                    else
                    begin
                        out_sample_reg <= y_c;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DIV) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        step_reg  <= 2'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (step_reg == 2'd2)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_FIN:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // hold until the output register frees up
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/cubic_fractional_resampler.sv
// The interpolator handles one output at a time: it takes a job, runs three multiply/add
// Horner steps on one shared multiplier, then rounds and divides by 6 with a reciprocal
// multiply, holding its result while the output is stalled. The front end takes one sample
// per cycle while not busy and issues one job per cycle while the job queue is not full.
// Reset (async, active low): history and phase zero, one sample owed, rate 1.0,
// 16-bit sample format, job queue and output register empty.
`default_nettype none

module cubic_fractional_resampler
    import crs_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] raw_sample,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [OUT_W-1:0]         interpolated_sample,
    output logic                            last_of_run,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [RATE_W-1:0]          cfg_data
);

    crs_push_t push;
    crs_job_t  head;
    logic      queue_full;
    logic      queue_empty;
    logic      pop;

    crs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .queue_full (queue_full)
    );

    crs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .pop   (pop),
        .empty (queue_empty),
        .head  (head)
    );

    crs_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .queue_empty         (queue_empty),
        .head                (head),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .interpolated_sample (interpolated_sample),
        .last_of_run         (last_of_run)
    );

endmodule

`default_nettype wire
